### rtl/core/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg - shared types and constants of the sorted key table
// Table size, key layout, status codes and the command and status groups
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_CHARS = 8;

  localparam int KEY_W    = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int STATUS_W = 2;
  localparam int HANDLE_W = 6;
  localparam int ENTRY_W  = 7;

  localparam int OUT_FIELDS_W = STATUS_W + HANDLE_W + ENTRY_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // only the top KEY_CHARS bytes of a key take part in a compare
  localparam logic [KEY_W-1:0] KEY_MASK =
    ~((KEY_W'(1) << (KEY_W - 8 * KEY_CHARS)) - KEY_W'(1));

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                load;
    logic                search;
    logic                key_rd;
    logic                compare;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                shift_start;
    logic                shift;
    logic                place;
    logic                emit;
  } skt_cmd_t;

  typedef struct packed {
    logic range_open;
    logic hit;
    logic op_insert;
    logic full;
    logic shift_rd;
    logic shift_wpend;
    logic out_free;
  } skt_sts_t;

endpackage

### rtl/core/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl - request sequencer of the sorted key table
// Steps the binary search, the decision, the order-store shift, the
// placement of a new entry and the hand-off to the output register.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  skt_pkg::skt_sts_t sts,
  output skt_pkg::skt_cmd_t cmd
);
  import skt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_KEYRD  = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;
  localparam logic [2:0] S_PLACE  = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.range_open) begin
          cmd.search = 1'b1;
          state_nxt  = S_KEYRD;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_KEYRD: begin
        cmd.key_rd = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = S_SEARCH;
      end
      S_DECIDE: begin
        priority if (sts.hit) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FOUND;
          state_nxt      = S_EMIT;
        end else if (!sts.op_insert) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOT_FOUND;
          state_nxt      = S_EMIT;
        end else if (sts.full) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
          state_nxt      = S_EMIT;
        end else begin
          cmd.shift_start = 1'b1;
          state_nxt       = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        // leave once every entry above the slot has moved up and landed
        if (!sts.shift_rd && !sts.shift_wpend) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/skt_dp.sv
// ----------------------------------------------------------------------------
// skt_dp - datapath of the sorted key table
// Key store and order store memories, binary search bounds, shift pointer,
// entry count and the registered result transaction.
// ----------------------------------------------------------------------------
module skt_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_operation,
  input  logic [skt_pkg::KEY_W-1:0]        in_key,
  input  skt_pkg::skt_cmd_t                cmd,
  output skt_pkg::skt_sts_t                sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [skt_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import skt_pkg::*;

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [IDX_W-1:0] ord_mem [CAPACITY];

  logic [KEY_W-1:0]       key_r;
  logic                   op_r;
  logic [CNT_W-1:0]       lo_r;
  logic [CNT_W-1:0]       hi_r;
  logic [IDX_W-1:0]       mid_r;
  logic [IDX_W-1:0]       h_r;
  logic                   found_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       sh_r;
  logic                   wpend_r;
  logic [IDX_W-1:0]       waddr_r;
  logic [STATUS_W-1:0]    status_r;
  logic [HANDLE_W-1:0]    handle_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [IDX_W-1:0] ord_q;
  logic [KEY_W-1:0] key_q;

  logic [CNT_W:0]   mid_sum;
  logic [CNT_W:0]   mid_half;
  logic [IDX_W-1:0] mid;
  logic [CNT_W-1:0] sh_dec;
  logic             shift_rd;
  logic [IDX_W-1:0] ord_raddr;
  logic             ord_we;
  logic [IDX_W-1:0] ord_waddr;
  logic [IDX_W-1:0] ord_wdata;
  logic             key_ge;
  logic             key_eq;
  logic             out_free;

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_half = mid_sum >> 1;
  assign mid      = mid_half[IDX_W-1:0];
  assign sh_dec   = sh_r - CNT_W'(1);
  assign shift_rd = sh_r > lo_r;
  assign key_ge   = key_q >= key_r;
  assign key_eq   = key_q == key_r;
  assign out_free = !out_valid_r || out_tready;

  assign ord_raddr = cmd.shift ? sh_dec[IDX_W-1:0] : mid;

  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = waddr_r;
    ord_wdata = ord_q;
    priority if (cmd.place) begin
      ord_we    = 1'b1;
      ord_waddr = lo_r[IDX_W-1:0];
      ord_wdata = count_r[IDX_W-1:0];
    end else if (cmd.shift && wpend_r) begin
      ord_we = 1'b1;
    end else begin
      ord_we = 1'b0;
    end
  end

  // order store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_q <= ord_mem[ord_raddr];
  end

  // key store: the read address is the handle just read from the order store
  always_ff @(posedge clk) begin
    if (cmd.place) begin
      key_mem[count_r[IDX_W-1:0]] <= key_r;
    end
    key_q <= key_mem[ord_q];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r        <= '0;
      hi_r        <= '0;
      found_r     <= 1'b0;
      count_r     <= '0;
      sh_r        <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        lo_r    <= '0;
        hi_r    <= count_r;
        found_r <= 1'b0;
      end
      if (cmd.compare) begin
        if (key_ge) begin
          hi_r <= CNT_W'(mid_r);
          // a match closes the range at the match itself
          if (key_eq) begin
            lo_r    <= CNT_W'(mid_r);
            found_r <= 1'b1;
          end
        end else begin
          lo_r <= CNT_W'(mid_r) + CNT_W'(1);
        end
      end
      if (cmd.shift_start) begin
        sh_r    <= count_r;
        wpend_r <= 1'b0;
      end
      if (cmd.shift) begin
        if (shift_rd) begin
          sh_r    <= sh_dec;
          wpend_r <= 1'b1;
        end else begin
          wpend_r <= 1'b0;
        end
      end
      if (cmd.place) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key & KEY_MASK;
      op_r  <= in_operation;
    end
    if (cmd.search) begin
      mid_r <= mid;
    end
    if (cmd.key_rd) begin
      h_r <= ord_q;
    end
    if (cmd.compare && key_ge && key_eq) begin
      handle_r <= HANDLE_W'(h_r);
    end
    if (cmd.shift && shift_rd) begin
      waddr_r <= sh_r[IDX_W-1:0];
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
      if (cmd.status != ST_FOUND) begin
        handle_r <= '0;
      end
    end
    if (cmd.place) begin
      status_r <= ST_INSERTED;
      handle_r <= HANDLE_W'(count_r[IDX_W-1:0]);
    end
    if (cmd.emit) begin
      out_data_r <= OUT_TDATA_W'({ENTRY_W'(count_r), handle_r, status_r});
    end
  end

  assign sts.range_open  = lo_r < hi_r;
  assign sts.hit         = found_r;
  assign sts.op_insert   = op_r;
  assign sts.full        = count_r == CNT_FULL;
  assign sts.shift_rd    = shift_rd;
  assign sts.shift_wpend = wpend_r;
  assign sts.out_free    = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_place_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |-> count_r < CNT_FULL)
    else $error("entry placed into a full table");

  a_place_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |-> !wpend_r && (sh_r == lo_r))
    else $error("entry placed before the order shift completed");

  a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.compare |=> (lo_r <= hi_r) && (hi_r <= count_r))
    else $error("search bounds out of order");

  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r || out_tready)
    else $error("result overwritten before it was taken");

endmodule

### rtl/core/sorted_key_table_find_or_insert.sv
// ----------------------------------------------------------------------------
// sorted_key_table_find_or_insert - sorted key table with find-or-insert
// Holds up to 64 eight-character keys in ascending order and answers each
// lookup or insert with a status, a stable entry handle and the entry count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: in_tdata carries the key (first character in the top
//   byte), in_tuser[0] the operation (0 find, 1 find or insert). One
//   transaction is taken at a time; in_tready is high only while idle.
//   Result channel out_*: one transaction per request, held in an output
//   register until taken, so the next request is accepted while it waits.
//   Sequence: a binary search over the order store runs through the search,
//   key read and compare states per step, up to 7 steps, then a range check
//   and a decision; an insert then moves every higher entry of the order
//   store up by one, one entry per cycle, then drains the shift and places
//   the new entry. The two stores have chained registered reads (order
//   store, then key store) and one write per cycle each.
//   Reset: clears the entry count and the control state; store contents are
//   not cleared, since entries at or above the count are never used.
//   When the receiver stalls, the finished result holds on out_tdata and the
//   next request waits in its final step until the output register frees.
// ----------------------------------------------------------------------------
module sorted_key_table_find_or_insert (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [skt_pkg::KEY_W-1:0]       in_tdata,  // [63:0] key
  input  logic                            in_tuser,  // [0] operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [skt_pkg::OUT_TDATA_W-1:0] out_tdata  // [1:0] status, [7:2] handle,
                                                     // [14:8] entry_count, [15] zero
);
  import skt_pkg::*;

  skt_cmd_t cmd;
  skt_sts_t sts;

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  skt_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_tuser),
    .in_key       (in_tdata),
    .cmd          (cmd),
    .sts          (sts),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

### test/sorted_key_table_find_or_insert_checker.sv
// ----------------------------------------------------------------------------
// sorted_key_table_find_or_insert_checker - result checker of the key table
// Watches both stream channels, keeps its own sorted copy of the table,
// works out the answer of each accepted request and compares every result
// transaction field by field with the oldest answer still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_table_find_or_insert_checker import skt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [KEY_W-1:0]       in_tdata,   // [63:0] key
  input  logic                   in_tuser,   // [0] operation
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [1:0] status, [7:2] handle,
                                             // [14:8] entry_count, [15] zero
  output int unsigned            pending,
  output int unsigned            errors
);

  // laid out as on out_tdata, status in the lowest bits
  typedef struct packed {
    logic [ENTRY_W-1:0]  entries;
    logic [HANDLE_W-1:0] handle;
    logic [STATUS_W-1:0] status;
  } answer_t;

  logic [KEY_W-1:0] stored_key    [CAPACITY];
  logic [IDX_W-1:0] sorted_handle [CAPACITY];
  int unsigned      held;
  answer_t          answers_due [$];
  answer_t          due;
  answer_t          got;
  int unsigned      err_cnt = 0;

  assign errors = err_cnt;

  task automatic report(input string what, input int unsigned seen, input int unsigned want);
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, seen, want);
    err_cnt++;
  endtask

  // walk the sorted order to the first key not below the request
  function automatic answer_t find_or_insert(input logic insert_req,
                                             input logic [KEY_W-1:0] raw_key);
    logic [KEY_W-1:0] key;
    int unsigned      slot;
    answer_t          ans;
    key  = raw_key & KEY_MASK;
    slot = held;
    for (int i = 0; i < held; i++) begin
      if (stored_key[sorted_handle[i]] >= key) begin
        slot = i;
        break;
      end
    end
    ans = '0;
    if (slot < held && stored_key[sorted_handle[slot]] == key) begin
      ans.status = ST_FOUND;
      ans.handle = HANDLE_W'(sorted_handle[slot]);
    end else if (!insert_req) begin
      ans.status = ST_NOT_FOUND;
    end else if (held >= CAPACITY) begin
      ans.status = ST_FULL;
    end else begin
      for (int i = held; i > slot; i--)
        sorted_handle[i] = sorted_handle[i-1];
      sorted_handle[slot] = IDX_W'(held);
      stored_key[held]    = key;
      ans.status          = ST_INSERTED;
      ans.handle          = HANDLE_W'(held);
      held++;
    end
    ans.entries = ENTRY_W'(held);
    return ans;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      held = 0;
      answers_due.delete();
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = answer_t'(out_tdata[OUT_FIELDS_W-1:0]);
        if (answers_due.size() == 0) begin
          report("result with no request outstanding", got, 0);
        end else begin
          due = answers_due.pop_front();
          if (got.status != due.status)
            report("status", got.status, due.status);
          if (got.handle != due.handle)
            report("handle", got.handle, due.handle);
          if (got.entries != due.entries)
            report("entry_count", got.entries, due.entries);
          if (out_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] != '0)
            report("pad bits", out_tdata[OUT_TDATA_W-1:OUT_FIELDS_W], 0);
        end
      end
      if (in_tvalid && in_tready)
        answers_due.push_back(find_or_insert(in_tuser, in_tdata));
      pending <= answers_due.size();
    end
  end

endmodule

### test/tb_sorted_key_table_find_or_insert.sv
// ----------------------------------------------------------------------------
// tb_sorted_key_table_find_or_insert - testbench of the sorted key table
// Sends a directed set of lookups and inserts, then random requests that
// mostly revisit held keys and their neighbors while the table fills up and
// runs full. Both channels stall at random outside a steady stretch; the checker judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_key_table_find_or_insert;
  import skt_pkg::*;

  localparam logic OP_FIND   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam int ITEMS        = 850;
  localparam int IDLE_PCT     = 25;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [KEY_W-1:0]       in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int unsigned            pending;
  int unsigned            errors;
  int unsigned            quiet_cycles = 0;
  bit                     steady = 1'b0;
  logic [KEY_W-1:0]       inserted_keys [$];

  sorted_key_table_find_or_insert i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sorted_key_table_find_or_insert_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .pending    (pending),
    .errors     (errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial out_tready = 1'b0;

  always @(posedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold valid across back-to-back requests; drop it only for an idle gap
  task automatic send_req(input logic op, input logic [KEY_W-1:0] key);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    if (op == OP_INSERT)
      inserted_keys.push_back(key);
  endtask

  function automatic logic [KEY_W-1:0] text_key(input int unsigned len, input bit holes);
    logic [KEY_W-1:0] k;
    logic [7:0]       ch;
    k = '0;
    for (int i = 0; i < len && i < KEY_CHARS; i++) begin
      ch = 8'($urandom_range(122, 97));
      if (holes && $urandom_range(4) == 0)
        ch = 8'h00;
      k[KEY_W-1-8*i -: 8] = ch;
    end
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    case ($urandom_range(3))
      0:       return {$urandom, $urandom};
      1:       return text_key($urandom_range(8, 1), 1'b1);
      default: return text_key($urandom_range(4, 1), 1'b0);
    endcase
  endfunction

  // a key sent for insert earlier, or one near it (plus or minus one, or its low byte inverted)
  function automatic logic [KEY_W-1:0] near_key();
    logic [KEY_W-1:0] k;
    k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
    case ($urandom_range(9))
      0:       k = k + 1'b1;
      1:       k = k - 1'b1;
      2:       k[7:0] = ~k[7:0];
      default: ;
    endcase
    return k;
  endfunction

  initial begin
    int unsigned roll;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_FIND;
    rst_n     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, extremes, embedded zero bytes, duplicates
    send_req(OP_FIND,   64'h0000_0000_0000_0000);
    send_req(OP_INSERT, 64'h6d00_0000_0000_0000);
    send_req(OP_INSERT, 64'h0000_0000_0000_0000);
    send_req(OP_INSERT, 64'hffff_ffff_ffff_ffff);
    send_req(OP_INSERT, 64'h6100_0000_0000_0000);
    send_req(OP_INSERT, 64'h6100_6200_0000_0000);
    send_req(OP_FIND,   64'h6100_6300_0000_0000);
    send_req(OP_FIND,   64'h6100_0000_0000_0000);
    send_req(OP_FIND,   64'h6100_6200_0000_0000);
    send_req(OP_INSERT, 64'h6d00_0000_0000_0000);
    send_req(OP_FIND,   64'hffff_ffff_ffff_ffff);
    send_req(OP_FIND,   64'h0000_0000_0000_0000);
    send_req(OP_FIND,   64'hffff_ffff_ffff_fffe);
    send_req(OP_INSERT, 64'h6162_6364_6566_6768);
    send_req(OP_INSERT, 64'h7a7a_7a7a_7a7a_7a7a);
    send_req(OP_FIND,   64'h6162_6364_6566_6768);
    send_req(OP_FIND,   64'h6162_6364_6566_6769);
    send_req(OP_INSERT, 64'h8000_0000_0000_0000);
    send_req(OP_FIND,   64'h5555_aaaa_5555_aaaa);
    send_req(OP_INSERT, 64'haaaa_5555_aaaa_5555);

    // fill the table gradually, then keep hitting it while full
    for (int n = 0; n < ITEMS; n++) begin
      steady <= (n >= 300 && n < 450);
      roll = $urandom_range(99);
      if (roll < 60 && inserted_keys.size() > 0)
        send_req(1'($urandom_range(1)), near_key());
      else if (roll < 85)
        send_req(OP_FIND, fresh_key());
      else
        send_req(OP_INSERT, fresh_key());
    end
    in_tvalid <= 1'b0;
    steady    <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### sorted_key_table_find_or_insert.f
rtl/core/skt_pkg.sv
rtl/core/skt_ctrl.sv
rtl/core/skt_dp.sv
rtl/core/sorted_key_table_find_or_insert.sv
test/sorted_key_table_find_or_insert_checker.sv
test/tb_sorted_key_table_find_or_insert.sv
